// ===== sv/c8ie_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c8ie_pkg
// Shared types and constants of the CHIP-8 instruction execute block.
// ----------------------------------------------------------------------------
package c8ie_pkg;

    localparam int PC_W             = 12;
    localparam int DATA_W           = 8;
    localparam int OPCODE_W         = 16;
    localparam int STATUS_W         = 3;
    localparam int STACK_DEPTH_DEF  = 16;

    localparam logic [PC_W-1:0]     START_ADDR_RST = 12'h200;
    localparam logic [3:0]          REG_VF         = 4'hF;
    localparam logic [3:0]          REG_V0         = 4'h0;
    localparam logic [OPCODE_W-1:0] OPC_RET        = 16'h00EE;
    localparam logic [OPCODE_W-1:0] OPC_CLS        = 16'h00E0;

    // Top nibble of the instruction word
    typedef enum logic [3:0] {
        OP_SYS     = 4'h0,
        OP_JP      = 4'h1,
        OP_CALL    = 4'h2,
        OP_SE_IMM  = 4'h3,
        OP_SNE_IMM = 4'h4,
        OP_SE_REG  = 4'h5,
        OP_LD_IMM  = 4'h6,
        OP_ADD_IMM = 4'h7,
        OP_ALU     = 4'h8,
        OP_SNE_REG = 4'h9,
        OP_LD_I    = 4'hA,
        OP_JP_V0   = 4'hB,
        OP_RND     = 4'hC,
        OP_DRW     = 4'hD,
        OP_KEY     = 4'hE,
        OP_MISC    = 4'hF
    } t_opgrp;

    // Low nibble of the 8xyn register ALU group
    typedef enum logic [3:0] {
        ALU_MOV  = 4'h0,
        ALU_OR   = 4'h1,
        ALU_AND  = 4'h2,
        ALU_XOR  = 4'h3,
        ALU_ADD  = 4'h4,
        ALU_SUB  = 4'h5,
        ALU_SHR  = 4'h6,
        ALU_SUBN = 4'h7,
        ALU_SHL  = 4'hE
    } t_aluop;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE      = 3'd0,
        ST_LEFT_OUT  = 3'd1,
        ST_UNKNOWN   = 3'd2,
        ST_OVERFLOW  = 3'd3,
        ST_UNDERFLOW = 3'd4
    } t_status;

    // Register file read request, taken when an instruction is accepted
    typedef struct packed {
        logic       en;
        logic [3:0] addr_a;
        logic [3:0] addr_b;
    } t_rf_rd;

    // Register file write, already qualified by a committed instruction
    typedef struct packed {
        logic              rw;
        logic [3:0]        addr;
        logic [DATA_W-1:0] data;
        logic              fw;
        logic              fv;
    } t_rf_wr;

    typedef struct packed {
        logic            push;
        logic            pop;
        logic [PC_W-1:0] pc;
    } t_stk_cmd;

    typedef struct packed {
        logic            empty;
        logic            full;
        logic [PC_W-1:0] tos;
    } t_stk_stat;

endpackage

// ===== sv/c8ie_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c8ie_if
// Valid/ready channels of the execute block: instruction, result, config.
// ----------------------------------------------------------------------------
interface c8ie_instr_if import c8ie_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [OPCODE_W-1:0] opcode;
    logic [DATA_W-1:0]   random_byte;

    modport source (output valid, opcode, random_byte, input ready);
    modport sink   (input valid, opcode, random_byte, output ready);
endinterface

interface c8ie_result_if import c8ie_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [PC_W-1:0]     next_pc;
    logic [PC_W-1:0]     index_value;
    logic                reg_write;
    logic [3:0]          reg_number;
    logic [DATA_W-1:0]   reg_value;
    logic                flag_write;
    logic                flag_value;
    logic [STATUS_W-1:0] status;

    modport source (output valid, next_pc, index_value, reg_write, reg_number, reg_value,
                    flag_write, flag_value, status, input ready);
    modport sink   (input valid, next_pc, index_value, reg_write, reg_number, reg_value,
                    flag_write, flag_value, status, output ready);
endinterface

interface c8ie_cfg_if import c8ie_pkg::*; ();
    logic            valid;
    logic            ready;
    logic [PC_W-1:0] start_address;

    modport source (output valid, start_address, input ready);
    modport sink   (input valid, start_address, output ready);
endinterface

// ===== sv/c8ie_regfile.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c8ie_regfile
// V0..VE in a two-read, one-write array with registered reads; VF in flops.
// ----------------------------------------------------------------------------
module c8ie_regfile import c8ie_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_rf_rd            i_rd,
    input  t_rf_wr            i_wr,
    output logic [DATA_W-1:0] o_va,
    output logic [DATA_W-1:0] o_vb
);

    logic [DATA_W-1:0] r_mem [0:15];
    logic [15:0]       r_valid;
    logic [DATA_W-1:0] r_vf;
    logic [DATA_W-1:0] n_vf;
    logic              mem_we;

    logic [DATA_W-1:0] r_mem_a, r_mem_b;
    logic              r_byp_a, r_byp_b;
    logic [DATA_W-1:0] r_byp_a_val, r_byp_b_val;
    logic              byp_a, byp_b;
    logic [DATA_W-1:0] byp_a_val, byp_b_val;

    // Bypass when the read hits VF, the entry written in the same cycle,
    // or an entry not written since reset (reads as zero).
    function automatic logic [DATA_W:0] bypass(
        input logic [3:0]        addr,
        input logic              we,
        input logic [3:0]        waddr,
        input logic [DATA_W-1:0] wdata,
        input logic              vld,
        input logic [DATA_W-1:0] vf
    );
        logic [DATA_W:0] res;
        res = '0;
        if (addr == REG_VF) begin
            res = {1'b1, vf};
        end else if (we && waddr == addr) begin
            res = {1'b1, wdata};
        end else if (!vld) begin
            res = {1'b1, {DATA_W{1'b0}}};
        end
        return res;
    endfunction

    assign mem_we = i_wr.rw && (i_wr.addr != REG_VF);

    always_comb begin
        priority if (i_wr.fw) begin
            n_vf = {{(DATA_W-1){1'b0}}, i_wr.fv};
        end else if (i_wr.rw && i_wr.addr == REG_VF) begin
            n_vf = i_wr.data;
        end else begin
            n_vf = r_vf;
        end
    end

    always_comb begin
        {byp_a, byp_a_val} = bypass(i_rd.addr_a, mem_we, i_wr.addr, i_wr.data,
                                    r_valid[i_rd.addr_a], n_vf);
        {byp_b, byp_b_val} = bypass(i_rd.addr_b, mem_we, i_wr.addr, i_wr.data,
                                    r_valid[i_rd.addr_b], n_vf);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_vf    <= '0;
        end else begin
            r_vf <= n_vf;
            if (mem_we) begin
                r_valid[i_wr.addr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        if (i_rd.en) begin
            r_mem_a     <= r_mem[i_rd.addr_a];
            r_mem_b     <= r_mem[i_rd.addr_b];
            r_byp_a     <= byp_a;
            r_byp_b     <= byp_b;
            r_byp_a_val <= byp_a_val;
            r_byp_b_val <= byp_b_val;
        end
    end

    assign o_va = r_byp_a ? r_byp_a_val : r_mem_a;
    assign o_vb = r_byp_b ? r_byp_b_val : r_mem_b;

endmodule

// ===== sv/c8ie_stack.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c8ie_stack
// Return stack: top entry in a register, the rest in a memory whose
// registered read always holds the entry just below the top.
// ----------------------------------------------------------------------------
module c8ie_stack import c8ie_pkg::*; #(
    parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_stk_cmd  i_cmd,
    output t_stk_stat o_stat
);

    localparam int LVL_W  = $clog2(STACK_DEPTH + 1);
    localparam int ADDR_W = $clog2(STACK_DEPTH);

    logic [PC_W-1:0]   r_mem [0:STACK_DEPTH-1];
    logic [LVL_W-1:0]  r_level;
    logic [LVL_W-1:0]  n_level;
    logic [LVL_W-1:0]  below_lvl;
    logic [PC_W-1:0]   r_tos;
    logic [PC_W-1:0]   r_below;

    always_comb begin
        priority if (i_cmd.push) begin
            n_level = r_level + LVL_W'(1);
        end else if (i_cmd.pop) begin
            n_level = r_level - LVL_W'(1);
        end else begin
            n_level = r_level;
        end
    end

    // Entry below the top after this cycle; never the entry pushed now
    assign below_lvl = n_level - LVL_W'(2);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level <= '0;
        end else begin
            r_level <= n_level;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_mem[r_level[ADDR_W-1:0]] <= i_cmd.pc;
            r_tos                      <= i_cmd.pc;
        end else if (i_cmd.pop) begin
            r_tos <= r_below;
        end
        r_below <= r_mem[below_lvl[ADDR_W-1:0]];
    end

    assign o_stat.empty = (r_level == '0);
    assign o_stat.full  = (r_level == LVL_W'(STACK_DEPTH));
    assign o_stat.tos   = r_tos;

endmodule

// ===== sv/chip8_instruction_execute_top.sv =====
`timescale 1ns / 1ps
// Stages: input register, then result register. Throughput: one instruction
// per cycle unless the result is stalled; the register file reads at accept time
// with a write bypass, so back-to-back dependent instructions run at full rate.
// Reset (synchronous, active low): V0..VF, index and stack level cleared,
// pc loaded with 0x200. A config write reloads the pc.
// ----------------------------------------------------------------------------
// chip8_instruction_execute_top
// CHIP-8 execute unit: jumps, calls, returns, skips, loads, register ALU, index, random.
// ----------------------------------------------------------------------------
module chip8_instruction_execute_top import c8ie_pkg::*; #(
    parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    c8ie_instr_if.sink   i_instr,
    c8ie_result_if.source o_result,
    c8ie_cfg_if.sink     i_cfg
);

    // Input stage
    logic                r_in_valid;
    logic [OPCODE_W-1:0] r_op;
    logic [DATA_W-1:0]   r_rnd;
    logic                in_xfer;
    logic                fire;

    // Architectural state
    logic [PC_W-1:0]     r_pc;
    logic [PC_W-1:0]     r_index;

    // Result stage
    logic                r_out_valid;
    logic [PC_W-1:0]     r_next_pc;
    logic [PC_W-1:0]     r_index_value;
    logic                r_reg_write;
    logic [3:0]          r_reg_number;
    logic [DATA_W-1:0]   r_reg_value;
    logic                r_flag_write;
    logic                r_flag_value;
    t_status             r_status;

    t_rf_rd              rf_rd;
    t_rf_wr              rf_wr;
    t_stk_cmd            stk_cmd;
    t_stk_stat           stk_stat;
    logic [DATA_W-1:0]   va;
    logic [DATA_W-1:0]   vb;

    // Decode / execute
    t_opgrp              grp;
    logic [3:0]          x;
    logic [DATA_W-1:0]   nn;
    logic [PC_W-1:0]     nnn;
    logic [PC_W-1:0]     pc_p2;
    logic [PC_W-1:0]     pc_p4;
    logic [DATA_W:0]     add_xy;
    logic [DATA_W:0]     sub_xy;
    logic [DATA_W:0]     sub_yx;
    logic [PC_W-1:0]     npc;
    logic [PC_W-1:0]     nindex;
    logic                rw;
    logic [DATA_W-1:0]   rv;
    logic                fw;
    logic                fv;
    t_status             status;
    logic                is_call;
    logic                is_ret;

    assign fire    = r_in_valid && (!r_out_valid || o_result.ready);
    assign in_xfer = i_instr.valid && i_instr.ready;

    assign i_instr.ready = !r_in_valid || fire;
    assign i_cfg.ready   = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_instr.ready) begin
            r_in_valid <= i_instr.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_op  <= i_instr.opcode;
            r_rnd <= i_instr.random_byte;
        end
    end

    // Bnnn reads V0 on port A; x is part of the address there
    assign rf_rd.en     = in_xfer;
    assign rf_rd.addr_a = (t_opgrp'(i_instr.opcode[15:12]) == OP_JP_V0) ?
                          REG_V0 : i_instr.opcode[11:8];
    assign rf_rd.addr_b = i_instr.opcode[7:4];

    c8ie_regfile u_regfile (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rd    (rf_rd),
        .i_wr    (rf_wr),
        .o_va    (va),
        .o_vb    (vb)
    );

    c8ie_stack #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_stack (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (stk_cmd),
        .o_stat  (stk_stat)
    );

    assign grp    = t_opgrp'(r_op[15:12]);
    assign x      = r_op[11:8];
    assign nn     = r_op[7:0];
    assign nnn    = r_op[11:0];
    assign pc_p2  = r_pc + PC_W'(2);
    assign pc_p4  = r_pc + PC_W'(4);
    assign add_xy = {1'b0, va} + {1'b0, vb};
    assign sub_xy = {1'b0, va} - {1'b0, vb};
    assign sub_yx = {1'b0, vb} - {1'b0, va};

    always_comb begin
        npc     = pc_p2;
        nindex  = r_index;
        rw      = 1'b0;
        rv      = '0;
        fw      = 1'b0;
        fv      = 1'b0;
        status  = ST_DONE;
        is_call = 1'b0;
        is_ret  = 1'b0;
        unique case (grp)
            OP_SYS: begin
                if (r_op == OPC_RET) begin
                    if (stk_stat.empty) begin
                        status = ST_UNDERFLOW;
                    end else begin
                        is_ret = 1'b1;
                        npc    = stk_stat.tos + PC_W'(2);
                    end
                end else if (r_op == OPC_CLS) begin
                    status = ST_LEFT_OUT;
                end else begin
                    status = ST_UNKNOWN;
                end
            end
            OP_JP: npc = nnn;
            OP_CALL: begin
                if (stk_stat.full) begin
                    status = ST_OVERFLOW;
                end else begin
                    is_call = 1'b1;
                    npc     = nnn;
                end
            end
            OP_SE_IMM:  if (va == nn) npc = pc_p4;
            OP_SNE_IMM: if (va != nn) npc = pc_p4;
            OP_SE_REG:  if (va == vb) npc = pc_p4;
            OP_SNE_REG: if (va != vb) npc = pc_p4;
            OP_LD_IMM: begin
                rw = 1'b1;
                rv = nn;
            end
            OP_ADD_IMM: begin
                rw = 1'b1;
                rv = va + nn;
            end
            OP_ALU: begin
                unique case (t_aluop'(r_op[3:0]))
                    ALU_MOV: begin rw = 1'b1; rv = vb;      end
                    ALU_OR:  begin rw = 1'b1; rv = va | vb; end
                    ALU_AND: begin rw = 1'b1; rv = va & vb; end
                    ALU_XOR: begin rw = 1'b1; rv = va ^ vb; end
                    ALU_ADD: begin
                        rw = 1'b1; rv = add_xy[DATA_W-1:0];
                        fw = 1'b1; fv = add_xy[DATA_W];
                    end
                    // flag is no-borrow
                    ALU_SUB: begin
                        rw = 1'b1; rv = sub_xy[DATA_W-1:0];
                        fw = 1'b1; fv = !sub_xy[DATA_W];
                    end
                    ALU_SHR: begin
                        rw = 1'b1; rv = {1'b0, va[DATA_W-1:1]};
                        fw = 1'b1; fv = va[0];
                    end
                    ALU_SUBN: begin
                        rw = 1'b1; rv = sub_yx[DATA_W-1:0];
                        fw = 1'b1; fv = !sub_yx[DATA_W];
                    end
                    ALU_SHL: begin
                        rw = 1'b1; rv = {va[DATA_W-2:0], 1'b0};
                        fw = 1'b1; fv = va[DATA_W-1];
                    end
                    default: status = ST_UNKNOWN;
                endcase
            end
            OP_LD_I:  nindex = nnn;
            OP_JP_V0: npc = nnn + {{(PC_W-DATA_W){1'b0}}, va};
            OP_RND: begin
                rw = 1'b1;
                rv = r_rnd & nn;
            end
            OP_DRW, OP_KEY, OP_MISC: status = ST_LEFT_OUT;
        endcase

        // Faulted instruction: no state change at all
        if (status != ST_DONE) begin
            npc     = r_pc;
            nindex  = r_index;
            rw      = 1'b0;
            rv      = '0;
            fw      = 1'b0;
            fv      = 1'b0;
            is_call = 1'b0;
            is_ret  = 1'b0;
        end
    end

    assign rf_wr.rw   = fire && rw;
    assign rf_wr.addr = x;
    assign rf_wr.data = rv;
    assign rf_wr.fw   = fire && fw;
    assign rf_wr.fv   = fv;

    assign stk_cmd.push = fire && is_call;
    assign stk_cmd.pop  = fire && is_ret;
    assign stk_cmd.pc   = r_pc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc    <= START_ADDR_RST;
            r_index <= '0;
        end else if (i_cfg.valid) begin
            r_pc    <= i_cfg.start_address;
        end else if (fire) begin
            r_pc    <= npc;
            r_index <= nindex;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_next_pc     <= npc;
            r_index_value <= nindex;
            r_reg_write   <= rw;
            r_reg_number  <= rw ? x : 4'h0;
            r_reg_value   <= rv;
            r_flag_write  <= fw;
            r_flag_value  <= fv;
            r_status      <= status;
        end
    end

    assign o_result.valid       = r_out_valid;
    assign o_result.next_pc     = r_next_pc;
    assign o_result.index_value = r_index_value;
    assign o_result.reg_write   = r_reg_write;
    assign o_result.reg_number  = r_reg_number;
    assign o_result.reg_value   = r_reg_value;
    assign o_result.flag_write  = r_flag_write;
    assign o_result.flag_value  = r_flag_value;
    assign o_result.status      = r_status;

endmodule
